@@ design/cholesky_factorizer_unit_assert.svh @@
// assertion macros used by the controller (chf_ctrl)
`ifndef CHOLESKY_FACTORIZER_UNIT_ASSERT_SVH
`define CHOLESKY_FACTORIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CHF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("chf assertion failed");
`define CHF_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("chf reset assertion failed");
`else
`define CHF_ASSERT(label, clk, rst_n, prop)
`define CHF_ASSERT_RST(label, clk, prop)
`endif

`endif

@@ design/chf_pkg.sv @@
package chf_pkg;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int SUM_W     = 48;
  localparam int ADDR_W    = 6;
  localparam int DEPTH     = 64;
  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int CNT_W     = 6;
  localparam int LOADC_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAGONAL_JITTER = 2'd1;

  localparam logic [CNT_W-1:0] SQRT_LAST_STEP = 6'd31;
  localparam logic [CNT_W-1:0] DIV_LAST_STEP  = 6'd63;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [3:0] {
    S_LOAD, S_RD_A, S_RD_B, S_INIT, S_RD_LI, S_RD_LJ, S_MUL, S_ACC,
    S_FIN, S_DLOAD, S_DIV, S_SQRT, S_WR, S_OUT_RD, S_OUT_SHOW, S_FAIL
  } chf_state_t;

  typedef struct packed {
    logic              mat_we;
    logic [ADDR_W-1:0] mat_waddr;
    logic [ADDR_W-1:0] mat_raddr;
    logic              fac_we;
    logic [ADDR_W-1:0] fac_waddr;
    logic [ADDR_W-1:0] fac_raddr;
    logic              cap_a;
    logic              init_acc;
    logic              diag;
    logic              cap_x;
    logic              do_mul;
    logic              do_acc;
    logic              start_sqrt;
    logic              start_div;
    logic              step_sqrt;
    logic              step_div;
    logic              out_load;
    logic              out_fail;
    logic              out_upper;
    logic              out_last;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
  } chf_cmd_t;

  typedef struct packed {
    logic sum_nonpos;
  } chf_stat_t;
endpackage

@@ design/chf_ram.sv @@
module chf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/chf_datapath.sv @@
module chf_datapath import chf_pkg::*; (
  input  logic              clk,
  input  chf_cmd_t          cmd,
  input  logic [CFG_W-1:0]  jitter,
  input  logic [DATA_W-1:0] in_data,
  output chf_stat_t         stat,
  output logic [IDX_W-1:0]  out_row_index,
  output logic [IDX_W-1:0]  out_col_index,
  output logic [DATA_W-1:0] out_factor_value,
  output logic              out_status,
  output logic              out_last
);
  logic [DATA_W-1:0] mat_rdata, fac_rdata, fac_wdata;
  logic [DATA_W-1:0] a_r, x_r;
  logic signed [ACC_W-1:0] acc_r, prod_r;
  logic signed [SUM_W-1:0] sum;
  logic signed [32:0] pair_sum;
  logic signed [32:0] half;
  logic signed [33:0] bval;
  logic signed [ACC_W:0] diff;
  logic signed [ACC_W:0] acc_max, acc_min;
  logic [ACC_W-1:0] acc_sat;

  // square root state
  logic [63:0] xs_r;
  logic [35:0] rem_r, rem_sh, trial;
  logic [31:0] root_r, sqrt_val;

  // divider state
  logic [63:0] dq_r;
  logic [31:0] drem_r, d_r, div_val;
  logic [32:0] dt;
  logic        dge, neg_r;
  logic [SUM_W-1:0] mag;

  chf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mat (
    .clk(clk), .we(cmd.mat_we), .waddr(cmd.mat_waddr), .wdata(in_data),
    .raddr(cmd.mat_raddr), .rdata(mat_rdata)
  );

  chf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_fac (
    .clk(clk), .we(cmd.fac_we), .waddr(cmd.fac_waddr), .wdata(fac_wdata),
    .raddr(cmd.fac_raddr), .rdata(fac_rdata)
  );

  assign sum             = acc_r[ACC_W-1:16];
  assign stat.sum_nonpos = sum[SUM_W-1] || (sum == '0);

  // floor of the mean, plus jitter on the diagonal
  always_comb begin
    pair_sum = {a_r[31], a_r} + {mat_rdata[31], mat_rdata};
    half     = pair_sum >>> 1;
    bval     = {half[32], half} + (cmd.diag ? {18'd0, jitter} : 34'd0);
  end

  always_comb begin
    acc_max = {1'b0, 1'b0, {(ACC_W-1){1'b1}}};
    acc_min = -acc_max;
    diff    = {acc_r[ACC_W-1], acc_r} - {prod_r[ACC_W-1], prod_r};
    if (diff > acc_max) begin
      acc_sat = acc_max[ACC_W-1:0];
    end else if (diff < acc_min) begin
      acc_sat = acc_min[ACC_W-1:0];
    end else begin
      acc_sat = diff[ACC_W-1:0];
    end
  end

  always_comb begin
    rem_sh = {rem_r[33:0], xs_r[63:62]};
    trial  = {2'b00, root_r, 2'b01};
    dt     = {drem_r, dq_r[63]};
    dge    = dt >= {1'b0, d_r};
    mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  end

  always_comb begin
    sqrt_val = root_r[31] ? 32'h7FFF_FFFF : root_r;
    if (!neg_r) begin
      div_val = (dq_r > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : dq_r[31:0];
    end else begin
      div_val = (dq_r > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : 32'(-dq_r[31:0]);
    end
    fac_wdata = cmd.diag ? sqrt_val : div_val;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_r <= mat_rdata;
    end
    if (cmd.cap_x) begin
      x_r <= fac_rdata;
    end
    if (cmd.do_mul) begin
      prod_r <= $signed(x_r) * $signed(fac_rdata);
    end
    if (cmd.init_acc) begin
      acc_r <= {{14{bval[33]}}, bval, 16'd0};
    end else if (cmd.do_acc) begin
      acc_r <= acc_sat;
    end

    if (cmd.start_sqrt) begin
      xs_r   <= {sum[SUM_W-1:0], 16'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.step_sqrt) begin
      xs_r <= {xs_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[30:0], 1'b0};
      end
    end

    if (cmd.start_div) begin
      dq_r   <= {mag, 16'd0};
      drem_r <= '0;
      neg_r  <= sum[SUM_W-1];
      d_r    <= ($signed(fac_rdata) <= 0) ? 32'd1 : fac_rdata;
    end else if (cmd.step_div) begin
      dq_r   <= {dq_r[62:0], dge};
      drem_r <= dge ? 32'(dt - {1'b0, d_r}) : dt[31:0];
    end

    if (cmd.out_load) begin
      out_row_index    <= cmd.out_fail ? '0 : cmd.out_row;
      out_col_index    <= cmd.out_fail ? '0 : cmd.out_col;
      out_factor_value <= (cmd.out_fail || cmd.out_upper) ? '0 : fac_rdata;
      out_status       <= cmd.out_fail ? STATUS_FAIL : STATUS_OK;
      out_last         <= cmd.out_fail || cmd.out_last;
    end
  end
endmodule

@@ design/chf_ctrl.sv @@
`include "cholesky_factorizer_unit_assert.svh"
module chf_ctrl import chf_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIM_W-1:0] size_cfg,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  chf_stat_t        stat,
  output chf_cmd_t         cmd
);
  chf_state_t st_r, st_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [DIM_W-1:0]   n_r, n_nxt, eff;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LOADC_W-1:0] ld_r, ld_nxt, ld_inc;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         nn;
  logic               full, in_acc, out_free, last_row, last_col, is_diag, more_k;
  logic [6:0]         lin_ij, lin_ji;

  always_comb begin
    if (size_cfg == '0) begin
      eff = DIM_W'(1);
    end else if (size_cfg > DIM_W'(MAX_DIM)) begin
      eff = DIM_W'(MAX_DIM);
    end else begin
      eff = size_cfg;
    end
    nn       = 8'(eff) * 8'(eff);
    ld_inc   = ld_r + 7'd1;
    full     = {1'b0, ld_inc} >= nn;
    in_acc   = in_valid && in_ready;
    out_free = !out_valid_r || out_ready;
    last_row = {1'b0, i_r} == (n_r - 4'd1);
    last_col = {1'b0, j_r} == (n_r - 4'd1);
    is_diag  = i_r == j_r;
    more_k   = ({1'b0, k_r} + 4'd1) < {1'b0, j_r};
    lin_ij   = 7'(i_r) * 7'(n_r) + 7'(j_r);
    lin_ji   = 7'(j_r) * 7'(n_r) + 7'(i_r);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_LOAD:     if (in_acc && full) st_nxt = S_RD_A;
      S_RD_A:     st_nxt = S_RD_B;
      S_RD_B:     st_nxt = S_INIT;
      S_INIT:     st_nxt = (j_r == '0) ? S_FIN : S_RD_LI;
      S_RD_LI:    st_nxt = S_RD_LJ;
      S_RD_LJ:    st_nxt = S_MUL;
      S_MUL:      st_nxt = S_ACC;
      S_ACC:      st_nxt = more_k ? S_RD_LI : S_FIN;
      S_FIN: begin
        if (!is_diag) st_nxt = S_DLOAD;
        else if (stat.sum_nonpos) st_nxt = S_FAIL;
        else st_nxt = S_SQRT;
      end
      S_DLOAD:    st_nxt = S_DIV;
      S_DIV:      if (cnt_r == DIV_LAST_STEP) st_nxt = S_WR;
      S_SQRT:     if (cnt_r == SQRT_LAST_STEP) st_nxt = S_WR;
      S_WR:       st_nxt = (is_diag && last_row) ? S_OUT_RD : S_RD_A;
      S_OUT_RD:   st_nxt = S_OUT_SHOW;
      S_OUT_SHOW: if (out_free) st_nxt = (last_row && last_col) ? S_LOAD : S_OUT_RD;
      S_FAIL:     if (out_free) st_nxt = S_LOAD;
      default:    st_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    cmd.diag  = is_diag;
    cmd.out_row = i_r;
    cmd.out_col = j_r;
    unique case (st_r)
      S_LOAD: begin
        in_ready      = 1'b1;
        cmd.mat_we    = in_acc;
        cmd.mat_waddr = ld_r[ADDR_W-1:0];
      end
      S_RD_A:  cmd.mat_raddr = lin_ij[ADDR_W-1:0];
      S_RD_B: begin
        cmd.mat_raddr = lin_ji[ADDR_W-1:0];
        cmd.cap_a     = 1'b1;
      end
      S_INIT:  cmd.init_acc = 1'b1;
      S_RD_LI: cmd.fac_raddr = {i_r, k_r};
      S_RD_LJ: begin
        cmd.fac_raddr = {j_r, k_r};
        cmd.cap_x     = 1'b1;
      end
      S_MUL:   cmd.do_mul = 1'b1;
      S_ACC:   cmd.do_acc = 1'b1;
      S_FIN: begin
        cmd.fac_raddr  = {j_r, j_r};
        cmd.start_sqrt = is_diag && !stat.sum_nonpos;
      end
      S_DLOAD: cmd.start_div = 1'b1;
      S_DIV:   cmd.step_div = 1'b1;
      S_SQRT:  cmd.step_sqrt = 1'b1;
      S_WR: begin
        cmd.fac_we    = 1'b1;
        cmd.fac_waddr = {i_r, j_r};
      end
      S_OUT_RD: cmd.fac_raddr = {i_r, j_r};
      S_OUT_SHOW: begin
        cmd.fac_raddr = {i_r, j_r};
        cmd.out_load  = out_free;
        cmd.out_upper = j_r > i_r;
        cmd.out_last  = last_row && last_col;
      end
      S_FAIL: begin
        cmd.out_load = out_free;
        cmd.out_fail = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    n_nxt   = n_r;
    cnt_nxt = cnt_r;
    ld_nxt  = ld_r;
    unique case (st_r)
      S_LOAD: begin
        if (in_acc) begin
          ld_nxt = ld_inc;
          if (full) begin
            ld_nxt = '0;
            n_nxt  = eff;
            i_nxt  = '0;
            j_nxt  = '0;
          end
        end
      end
      S_INIT:  k_nxt = '0;
      S_ACC:   k_nxt = k_r + 3'd1;
      S_FIN, S_DLOAD: cnt_nxt = '0;
      S_DIV, S_SQRT:  cnt_nxt = cnt_r + 6'd1;
      S_WR: begin
        if (!is_diag) begin
          j_nxt = j_r + 3'd1;
        end else if (!last_row) begin
          i_nxt = i_r + 3'd1;
          j_nxt = '0;
        end else begin
          i_nxt = '0;
          j_nxt = '0;
        end
      end
      S_OUT_SHOW: begin
        if (out_free) begin
          if (last_col) begin
            j_nxt = '0;
            i_nxt = i_r + 3'd1;
          end else begin
            j_nxt = j_r + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_LOAD;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      n_r         <= DIM_W'(MAX_DIM);
      cnt_r       <= '0;
      ld_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      ld_r        <= ld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CHF_ASSERT(a_lower_tri, clk, rst_n, ((st_r == S_RD_A) || (st_r == S_INIT) || (st_r == S_FIN) || (st_r == S_WR)) |-> (j_r <= i_r))
  `CHF_ASSERT(a_k_below_j, clk, rst_n, ((st_r == S_RD_LI) || (st_r == S_MUL) || (st_r == S_ACC)) |-> (k_r < j_r))
  `CHF_ASSERT_RST(a_reset_idle, clk, (!rst_n) |=> (!out_valid_r && (st_r == S_LOAD)))
endmodule

@@ design/cholesky_factorizer_unit.sv @@
// loading takes n*n transfers in all, one element taken whenever in_valid and in_ready;
// factoring an n x n matrix: per lower entry a multiply-accumulate over earlier
// columns, then a diagonal square root or a division (one quotient bit per cycle);
// the divider dominates; results leave one at a time as out_ready allows, and the
// next matrix loads while the last result waits
// synchronous active-low reset: size 8, jitter 0, load count zero, no result pending
module cholesky_factorizer_unit import chf_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_element_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_row_index,
  output logic [IDX_W-1:0]     out_col_index,
  output logic [DATA_W-1:0]    out_factor_value,
  output logic                 out_status,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);
  logic [DIM_W-1:0] size_r;
  logic [CFG_W-1:0] jitter_r;
  chf_cmd_t  cmd;
  chf_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= DIM_W'(8);
      jitter_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MATRIX_SIZE) begin
        size_r <= cfg_data[DIM_W-1:0];
      end else if (cfg_index == CFG_DIAGONAL_JITTER) begin
        jitter_r <= cfg_data;
      end
    end
  end

  chf_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .size_cfg(size_r),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  chf_datapath u_dp (
    .clk(clk), .cmd(cmd), .jitter(jitter_r), .in_data(in_element_value),
    .stat(stat),
    .out_row_index(out_row_index), .out_col_index(out_col_index),
    .out_factor_value(out_factor_value), .out_status(out_status),
    .out_last(out_last)
  );
endmodule

@@ dv/tb_cholesky_factorizer_unit.sv @@
module tb_cholesky_factorizer_unit;
  import chf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam longint ACC_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_BOT = -ACC_TOP;
  localparam int ITEM_TARGET = 370;

  typedef struct {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              status;
    logic              last;
  } factor_entry_t;

  class factor_scoreboard;
    int            mat[64];
    int            fac[64];
    int unsigned   load_cnt;
    logic [3:0]    dim_reg;
    logic [15:0]   jitter_reg;
    factor_entry_t pending_q[$];
    int            errors;

    function new();
      load_cnt = 0;
      dim_reg = 4'd8;
      jitter_reg = 16'd0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_MATRIX_SIZE) dim_reg = data[3:0];
      else if (idx == CFG_DIAGONAL_JITTER) jitter_reg = data;
    endfunction

    function int dim();
      if (dim_reg < 1) return 1;
      if (dim_reg > 8) return 8;
      return dim_reg;
    endfunction

    function longint sub_sat(longint acc, longint p);
      if (p > 0 && acc < ACC_BOT + p) return ACC_BOT;
      if (p < 0 && acc > ACC_TOP + p) return ACC_TOP;
      return acc - p;
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    function longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function bit factorize(int n);
      longint b, acc, sum, d, q;
      longint unsigned mag;
      for (int i = 0; i < n * n; i++) fac[i] = 0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j <= i; j++) begin
          b = (longint'(mat[i*n+j]) + longint'(mat[j*n+i])) >>> 1;
          if (i == j) b += longint'(jitter_reg);
          acc = b * 65536;
          for (int k = 0; k < j; k++)
            acc = sub_sat(acc, longint'(fac[i*n+k]) * longint'(fac[j*n+k]));
          sum = acc >>> 16;
          if (i == j) begin
            if (sum <= 0) return 0;
            fac[i*n+j] = clamp32(longint'(root64(longint'(unsigned'(sum)) << 16)));
          end else begin
            d = fac[j*n+j];
            if (d <= 0) d = 1;
            mag = (sum >= 0) ? sum : -sum;
            q = (mag << 16) / d;
            if (q > 64'sd4294967296) q = 64'sd4294967296;
            fac[i*n+j] = clamp32(sum >= 0 ? q : -q);
          end
        end
      end
      return 1;
    endfunction

    function void note_input(logic [DATA_W-1:0] v);
      int n;
      factor_entry_t e;
      n = dim();
      mat[load_cnt & 63] = v;
      load_cnt = (load_cnt + 1) & 127;
      if (load_cnt < n * n) return;
      load_cnt = 0;
      if (!factorize(n)) begin
        e.row = '0; e.col = '0; e.value = '0; e.status = STATUS_FAIL; e.last = 1'b1;
        pending_q.push_back(e);
        return;
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          e.row = IDX_W'(i); e.col = IDX_W'(j); e.value = fac[i*n+j];
          e.status = STATUS_OK;
          e.last = (i == n - 1) && (j == n - 1);
          pending_q.push_back(e);
        end
    endfunction

    function void check_result(factor_entry_t got);
      factor_entry_t w;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result row %0d col %0d value %h status %b last %b",
                   got.row, got.col, got.value, got.status, got.last);
        return;
      end
      w = pending_q.pop_front();
      if (got.row !== w.row || got.col !== w.col || got.value !== w.value ||
          got.status !== w.status || got.last !== w.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected r%0d c%0d %h s%b l%b, got r%0d c%0d %h s%b l%b",
                   w.row, w.col, w.value, w.status, w.last,
                   got.row, got.col, got.value, got.status, got.last);
      end
    endfunction

    function int waiting();
      return pending_q.size();
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_element_value = '0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [IDX_W-1:0]     out_row_index;
  logic [IDX_W-1:0]     out_col_index;
  logic [DATA_W-1:0]    out_factor_value;
  logic                 out_status;
  logic                 out_last;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  factor_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;
  int stall_left = 0;
  int stall_mode = 0;

  cholesky_factorizer_unit dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_element_value,
    .out_valid, .out_ready, .out_row_index, .out_col_index, .out_factor_value,
    .out_status, .out_last, .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 2_000_000);
    $display("tb_cholesky_factorizer_unit: FAIL");
    $finish;
  end

  // receiver stall pattern: runs of always-ready, light and heavy stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    factor_entry_t got;
    if (rst_n && out_valid && out_ready) begin
      got.row = out_row_index;
      got.col = out_col_index;
      got.value = out_factor_value;
      got.status = out_status;
      got.last = out_last;
      sb.check_result(got);
    end
  end

  task automatic send_element(logic [DATA_W-1:0] v);
    in_valid <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(v);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.waiting() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_W-1:0] size, logic [CFG_W-1:0] jitter, bit spare);
    if (spare) reg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                         CFG_W'($urandom));
    reg_write(CFG_MATRIX_SIZE, size);
    reg_write(CFG_DIAGONAL_JITTER, jitter);
    cfg_we <= 1'b0;
  endtask

  task automatic send_matrix(int kind);
    int n;
    logic [DATA_W-1:0] a[64];
    n = sb.dim();
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        if (kind == 0)
          a[i*n+j] = $urandom;
        else if (i == j)
          a[i*n+j] = $urandom_range(32'h0010_0000, 32'h0100_0000);
        else
          a[i*n+j] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      end
    for (int k = 0; k < n * n; k++) send_element(a[k]);
  endtask

  initial begin
    int sz, jit, nmat;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(1, 0, 1);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0000);
    send_element(32'h8000_0000);
    send_element(32'h0001_0000);
    drain();

    // size 0 acts as 1; jitter alone carries the diagonal
    set_regs(0, 16'hFFFF, 0);
    send_element(32'h0000_0000);
    send_element(32'h8000_0000);
    drain();

    set_regs(2, 0, 1);
    send_element(32'h0001_0000); send_element(32'h0000_0000);
    send_element(32'h0000_0000); send_element(32'h0001_0000);
    send_element(32'h0000_0001); send_element(32'h7FFF_FFFF);
    send_element(32'h7FFF_FFFF); send_element(32'h7FFF_FFFF);
    send_element(32'h7FFF_FFFF); send_element(32'h8000_0000);
    send_element(32'h8000_0000); send_element(32'h7FFF_FFFF);
    drain();

    // shrink the size mid-load: the next transfer starts the factorization
    set_regs(3, 100, 0);
    send_element(32'h0004_0000); send_element(32'h0000_8000);
    send_element(32'hFFFF_0000); send_element(32'h0000_4000);
    send_element(32'h0003_0000);
    drain();
    set_regs(2, 100, 0);
    send_element(32'h0002_0000);
    drain();

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: sz = 0;
        1: sz = $urandom_range(5, 8);
        2: sz = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 4);
        default: sz = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 3))
        0: jit = 0;
        1: jit = 16'hFFFF;
        default: jit = $urandom_range(0, 16'hFFFF);
      endcase
      set_regs(CFG_W'(sz | ($urandom_range(0, 4095) << 4)), CFG_W'(jit),
               $urandom_range(0, 3) == 0);
      nmat = $urandom_range(1, 3);
      repeat (nmat) send_matrix($urandom_range(0, 3) == 0 ? 0 : 1);
      drain();
    end

    while (sb.waiting() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0)
      $display("tb_cholesky_factorizer_unit: PASS");
    else
      $display("tb_cholesky_factorizer_unit: FAIL");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/chf_pkg.sv
design/chf_ram.sv
design/chf_datapath.sv
design/chf_ctrl.sv
design/cholesky_factorizer_unit.sv
dv/tb_cholesky_factorizer_unit.sv
